FILE: hw/rtl/pcxrld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrld_pkg
// shared types, constants and helpers of the pcx run-length line decoder
// ----------------------------------------------------------------------------
package pcxrld_pkg;

  localparam int unsigned DefPaletteEntries = 256;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PixelW   = 15;
  localparam int unsigned LineW    = 16;
  localparam int unsigned CountW   = 6;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned ColorShift = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  localparam logic [ByteW-1:0]  MarkerMin = 8'hC0;
  localparam logic [CountW-1:0] CountMask = 6'h3F;

  localparam logic             OutputModeReset = 1'b1;
  localparam logic [LineW-1:0] LineBytesReset  = 16'd640;

  typedef enum logic {
    KindPalette = 1'b0,
    KindStream  = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOutputMode = 1'b0,
    CfgLineBytes  = 1'b1
  } cfg_reg_e;

  // one decoded run handed to the emitter
  typedef struct packed {
    logic [ByteW-1:0]  idx;
    logic [CountW-1:0] count;
    logic              ends;
    logic              oob;
  } job_t;

  // palette write request
  typedef struct packed {
    logic              we;
    logic [ByteW-1:0]  idx;
    logic [PixelW-1:0] data;
  } pal_wr_t;

  // 5:5:5 packing, red in the top bits, each channel the top bits of its byte
  function automatic logic [PixelW-1:0] pack555(input logic [ByteW-1:0] r,
                                                input logic [ByteW-1:0] g,
                                                input logic [ByteW-1:0] b);
    logic [ChanW-1:0] rc, gc, bc;
    rc = r[ByteW-1:ColorShift];
    gc = g[ByteW-1:ColorShift];
    bc = b[ByteW-1:ColorShift];
    return {rc, gc, bc};
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pcxrld_palette_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrld_palette_ram
// palette store, one write and one registered read port
// ----------------------------------------------------------------------------
module pcxrld_palette_ram
  import pcxrld_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = DefPaletteEntries,
  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [PixelW-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output      logic [PixelW-1:0] rdata_o
);

  logic [PixelW-1:0] mem [PALETTE_ENTRIES];
  logic [PixelW-1:0] rdata_q;

  // read data holds between reads, so a run keeps its colour
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pcxrld_byte_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrld_byte_parser
// marker/literal parsing, run state and scan line counting
// ----------------------------------------------------------------------------
module pcxrld_byte_parser
  import pcxrld_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = DefPaletteEntries
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              kind_i,
  input  wire logic [ByteW-1:0]  data_byte_i,
  input  wire logic [ByteW-1:0]  palette_index_i,
  input  wire logic [ByteW-1:0]  red_i,
  input  wire logic [ByteW-1:0]  green_i,
  input  wire logic [ByteW-1:0]  blue_i,
  input  wire logic [LineW-1:0]  line_bytes_i,
  output      pal_wr_t           pal_wr_o,
  output      logic              job_start_o,
  output      job_t              job_o
);

  logic              run_pending_q, run_pending_d;
  logic [CountW-1:0] run_count_q, run_count_d;
  logic [LineW-1:0]  line_left_q, line_left_d;
  logic [CountW-1:0] n;
  logic [LineW-1:0]  left;
  logic [LineW-1:0]  n_ext;
  logic              ends;
  logic              stream;

  assign stream = accept_i && (kind_e'(kind_i) == KindStream);
  assign n_ext  = {{(LineW-CountW){1'b0}}, n};
  // zero means reload before the next pixel
  assign left   = (line_left_q == '0) ? line_bytes_i : line_left_q;
  assign ends   = n_ext >= left;

  always_comb begin
    run_pending_d = run_pending_q;
    run_count_d   = run_count_q;
    line_left_d   = line_left_q;
    n             = '0;
    if (stream) begin
      if (run_pending_q) begin
        n             = run_count_q;
        run_pending_d = 1'b0;
        run_count_d   = '0;
      end else if (data_byte_i >= MarkerMin) begin
        run_pending_d = 1'b1;
        run_count_d   = data_byte_i[CountW-1:0] & CountMask;
      end else begin
        n = CountW'(1);
      end
      if (n != '0) begin
        line_left_d = ends ? '0 : (left - n_ext);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_pending_q <= 1'b0;
      run_count_q   <= '0;
      line_left_q   <= '0;
    end else begin
      run_pending_q <= run_pending_d;
      run_count_q   <= run_count_d;
      line_left_q   <= line_left_d;
    end
  end

  assign job_start_o = stream && (n != '0);
  assign job_o.idx   = data_byte_i;
  assign job_o.count = n;
  assign job_o.ends  = ends;
  assign job_o.oob   = {1'b0, data_byte_i} >= (ByteW+1)'(PALETTE_ENTRIES);

  // loads beyond the palette are dropped
  assign pal_wr_o.we   = accept_i && (kind_e'(kind_i) == KindPalette) &&
                         ({1'b0, palette_index_i} < (ByteW+1)'(PALETTE_ENTRIES));
  assign pal_wr_o.idx  = palette_index_i;
  assign pal_wr_o.data = pack555(red_i, green_i, blue_i);

endmodule
`default_nettype wire

FILE: hw/rtl/pcxrld_pixel_emitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrld_pixel_emitter
// repeats one run word by word into the output register
// ----------------------------------------------------------------------------
module pcxrld_pixel_emitter
  import pcxrld_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                job_start_i,
  input  wire job_t                job_i,
  input  wire logic [PixelW-1:0]   rd_data_i,
  input  wire logic                output_mode_i,
  output      logic                take_o,
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output      logic [OutDataW-1:0] m_axis_tdata_o,
  output      logic                m_axis_tlast_o,
  output      logic                m_axis_tuser_o
);

  logic [CountW-1:0] rem_q, rem_d;
  logic [ByteW-1:0]  idx_q;
  logic              ends_q, oob_q;
  logic              out_valid_q, out_valid_d;
  logic [PixelW-1:0] out_pixel_q, pixel;
  logic              out_last_q, out_line_end_q;
  logic              emit;
  logic              final_word;

  assign emit       = (rem_q != '0) && (!out_valid_q || m_axis_tready_i);
  assign final_word = rem_q == CountW'(1);
  assign take_o     = (rem_q == '0) || (final_word && emit);

  // palette read data stays put while the run drains
  assign pixel = output_mode_i ? (oob_q ? '0 : rd_data_i)
                               : {{(PixelW-ByteW){1'b0}}, idx_q};

  always_comb begin
    rem_d = rem_q;
    if (job_start_i) begin
      rem_d = job_i.count;
    end else if (emit) begin
      rem_d = rem_q - CountW'(1);
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_start_i) begin
      idx_q  <= job_i.idx;
      ends_q <= job_i.ends;
      oob_q  <= job_i.oob;
    end
    if (emit) begin
      out_pixel_q    <= pixel;
      out_last_q     <= final_word;
      out_line_end_q <= final_word && ends_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-PixelW){1'b0}}, out_pixel_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_line_end_q;

  a_line_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_line_end_q |-> out_last_q)
    else $error("line end flagged on a word that is not the last of its item");

  a_start_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_start_i |-> (job_i.count != '0) && take_o)
    else $error("run started empty or while another run is draining");

  a_start_loads_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_start_i |=> rem_q == $past(job_i.count))
    else $error("run count not loaded");

  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) && !out_valid_q |=> out_valid_q)
    else $error("pending run did not reach the output register");

endmodule
`default_nettype wire

FILE: hw/rtl/pcx_rle_line_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder_top
// pcx run-length line decoder with 5:5:5 palette lookup
// ----------------------------------------------------------------------------
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tuser kind, tdata stream byte or palette load
// m_axis    out  m_axis_tvalid/tready       tdata pixel, tlast last, tuser line_end
// cfg       in   cfg_we                     cfg_index, cfg_data
//
// a literal, a marker or a palette load is taken in one handshake; a run of n
// pixels holds the input while the emitter's countdown feeds its words into the
// single output register. the palette read is issued at the accept edge, so
// the colour is ready when the first word is built. no clearing pass after
// reset: unwritten palette entries read as whatever the memory holds.
// output stalls back up into the input once the current run is drained.
// ----------------------------------------------------------------------------
module pcx_rle_line_decoder_top
  import pcxrld_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = DefPaletteEntries
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  // data_byte, palette_index, red, green, blue
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // kind
  input  wire logic                s_axis_tuser,
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // pixel, zero pad
  output      logic [OutDataW-1:0] m_axis_tdata,
  output      logic                m_axis_tlast,
  // line_end
  output      logic                m_axis_tuser,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);

  logic              output_mode_q;
  logic [LineW-1:0]  line_bytes_q;
  logic              accept;
  logic              take;
  pal_wr_t           pal_wr;
  job_t              job;
  logic              job_start;
  logic [PixelW-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_mode_q <= OutputModeReset;
      line_bytes_q  <= LineBytesReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgOutputMode: output_mode_q <= cfg_data_i[0];
        CfgLineBytes:  line_bytes_q  <= cfg_data_i[LineW-1:0];
        default:       ;
      endcase
    end
  end

  assign s_axis_tready = take;
  assign accept        = s_axis_tvalid && take;

  pcxrld_byte_parser #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .kind_i          (s_axis_tuser),
    .data_byte_i     (s_axis_tdata[7:0]),
    .palette_index_i (s_axis_tdata[15:8]),
    .red_i           (s_axis_tdata[23:16]),
    .green_i         (s_axis_tdata[31:24]),
    .blue_i          (s_axis_tdata[39:32]),
    .line_bytes_i    (line_bytes_q),
    .pal_wr_o        (pal_wr),
    .job_start_o     (job_start),
    .job_o           (job)
  );

  pcxrld_palette_ram #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_wr.we),
    .waddr_i (pal_wr.idx[AddrW-1:0]),
    .wdata_i (pal_wr.data),
    .re_i    (job_start),
    .raddr_i (job.idx[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  pcxrld_pixel_emitter u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_start_i     (job_start),
    .job_i           (job),
    .rd_data_i       (rd_data),
    .output_mode_i   (output_mode_q),
    .take_o          (take),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

endmodule
`default_nettype wire
